// File: sv/line_substring_matcher_assert.svh
// Assertion macros shared by the checker files of the line filter.
// No dependencies; each macro expands to one labeled concurrent assertion.
`ifndef LINE_SUBSTRING_MATCHER_ASSERT_SVH
`define LINE_SUBSTRING_MATCHER_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent, quiet during reset.
`define LSM_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("line filter check failed");

// Consequent checked in the cycle after the antecedent, quiet during reset.
`define LSM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("line filter check failed");

// Consequent checked in the cycle after the antecedent, also across reset.
`define LSM_ASSERT_NEXT_ANY(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("line filter check failed");

`endif

// File: sv/lsm_pkg.sv
// Shared types, constants and helper functions of the line filter.
// No dependencies; imported by every module of the block.
package lsm_pkg;

   localparam int PATTERN_MAX   = 16;
   localparam int PATTERN_BYTES = 16;   // bytes held by the two pattern registers
   localparam int LEN_W         = $clog2(PATTERN_MAX + 1);
   localparam int CFG_LEN_W     = 5;
   localparam int COUNT_W       = 32;
   localparam int CSR_DATA_W    = 64;
   localparam int CSR_ADDR_W    = 6;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] NEWLINE_BYTE = 8'd10;
   localparam logic       KIND_LINE    = 1'b0;
   localparam logic       KIND_FINAL   = 1'b1;

   typedef enum logic [2:0] {
      REG_PATTERN_LOW    = 3'd0,
      REG_PATTERN_HIGH   = 3'd1,
      REG_PATTERN_LENGTH = 3'd2,
      REG_FOLD_CASE      = 3'd3,
      REG_INVERT_SELECT  = 3'd4,
      REG_TOTALS_ONLY    = 3'd5
   } lsm_reg_type;

   typedef struct packed {
      logic [PATTERN_BYTES*8-1:0] pattern;
      logic [CFG_LEN_W-1:0]       pattern_length;
      logic                       fold_case;
      logic                       invert_select;
      logic                       totals_only;
   } lsm_cfg_type;

   typedef struct packed {
      logic               result_kind;
      logic [COUNT_W-1:0] line_number;
      logic [COUNT_W-1:0] selected_count;
      logic               last_result;
   } lsm_result_type;

   // Up to two results per item, packed so that "first" is always used first.
   typedef struct packed {
      logic [1:0]     count;
      lsm_result_type first;
      lsm_result_type second;
   } lsm_push_type;

   function automatic logic [7:0] fold_byte(input logic [7:0] b, input logic ic);
      if (ic && b >= 8'd65 && b <= 8'd90) begin
         return b + 8'd32;
      end
      return b;
   endfunction

   function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
      return (v == '1) ? v : v + COUNT_W'(1);
   endfunction

endpackage

// File: sv/lsm_match_core.sv
// Per-line shift-and matcher, line and selection counters of the line filter.
// Depends on lsm_pkg; produces up to two results per accepted item.
module lsm_match_core
   import lsm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  lsm_cfg_type  cfg,
   input  logic         accept,
   input  logic [7:0]   text_byte,
   input  logic         end_of_text,
   output lsm_push_type push
);

   logic [PATTERN_MAX-1:0] progress_ff, progress_in;
   logic                   found_ff, found_in;
   logic                   nonempty_ff, nonempty_in;
   logic [COUNT_W-1:0]     line_cnt_ff, line_cnt_in;
   logic [COUNT_W-1:0]     sel_cnt_ff, sel_cnt_in;

   logic [LEN_W-1:0]       used_len;
   logic [PATTERN_MAX-1:0] byte_mask;
   logic [PATTERN_MAX-1:0] prog_step;
   logic [7:0]             fc;
   logic [7:0]             pat_b;
   logic                   is_newline;
   logic                   step_found;
   logic                   step_nonempty;
   logic                   close_line;
   logic                   hit;
   logic                   selected;
   logic                   line_report;
   lsm_result_type         line_res;
   lsm_result_type         final_res;

   always_comb begin
      if (32'(cfg.pattern_length) > PATTERN_MAX) begin
         used_len = LEN_W'(PATTERN_MAX);
      end else begin
         used_len = LEN_W'(cfg.pattern_length);
      end
   end

   // Bit-parallel compare of the folded byte against every pattern position.
   always_comb begin
      fc = fold_byte(text_byte, cfg.fold_case);
      byte_mask = '0;
      for (int i = 0; i < PATTERN_MAX; i++) begin
         pat_b = (i < PATTERN_BYTES) ? cfg.pattern[i*8 +: 8] : 8'h00;
         byte_mask[i] = (32'(used_len) > i) &&
                        (fold_byte(pat_b, cfg.fold_case) == fc);
      end
   end

   always_comb begin
      is_newline    = (text_byte == NEWLINE_BYTE);
      prog_step     = progress_ff;
      step_found    = found_ff;
      step_nonempty = nonempty_ff;
      if (!is_newline) begin
         step_nonempty = 1'b1;
         if (used_len != '0) begin
            prog_step = {progress_ff[PATTERN_MAX-2:0], 1'b1} & byte_mask;
            for (int i = 0; i < PATTERN_MAX; i++) begin
               if (prog_step[i] && (32'(used_len) == i + 1)) begin
                  step_found = 1'b1;
               end
            end
         end
      end

      close_line  = is_newline || end_of_text;
      hit         = (used_len == '0) ? 1'b1 : step_found;
      selected    = hit ^ cfg.invert_select;
      line_cnt_in = line_cnt_ff;
      sel_cnt_in  = sel_cnt_ff;
      line_report = 1'b0;
      if (close_line && step_nonempty) begin
         line_cnt_in = sat_inc(line_cnt_ff);
         if (selected) begin
            sel_cnt_in  = sat_inc(sel_cnt_ff);
            line_report = !cfg.totals_only;
         end
      end

      line_res.result_kind     = KIND_LINE;
      line_res.line_number     = line_cnt_in;
      line_res.selected_count  = sel_cnt_in;
      line_res.last_result     = 1'b0;
      final_res.result_kind    = KIND_FINAL;
      final_res.line_number    = line_cnt_in;
      final_res.selected_count = sel_cnt_in;
      final_res.last_result    = 1'b1;

      push.first  = line_report ? line_res : final_res;
      push.second = final_res;
      push.count  = accept ? (2'(line_report) + 2'(end_of_text)) : 2'd0;

      if (close_line) begin
         progress_in = '0;
         found_in    = 1'b0;
         nonempty_in = 1'b0;
      end else begin
         progress_in = prog_step;
         found_in    = step_found;
         nonempty_in = step_nonempty;
      end
      if (end_of_text) begin
         line_cnt_in = '0;
         sel_cnt_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         progress_ff <= '0;
         found_ff    <= 1'b0;
         nonempty_ff <= 1'b0;
         line_cnt_ff <= '0;
         sel_cnt_ff  <= '0;
      end else if (accept) begin
         progress_ff <= progress_in;
         found_ff    <= found_in;
         nonempty_ff <= nonempty_in;
         line_cnt_ff <= line_cnt_in;
         sel_cnt_ff  <= sel_cnt_in;
      end
   end

endmodule

// File: sv/lsm_result_queue.sv
// Small result queue of the line filter: takes up to two results a cycle,
// gives one. Depends on lsm_pkg for the result and push types.
module lsm_result_queue
   import lsm_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  lsm_push_type   push,
   input  logic           pop,
   output lsm_result_type head,
   output logic           head_valid,
   output logic           has_room
);

   lsm_result_type    entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;
   logic              do_pop;

   assign head_valid = (cnt_ff != '0);
   assign head       = entry_ff[rd_ptr_ff];
   // room for a worst-case item (two results)
   assign has_room   = (cnt_ff <= QCNT_W'(QUEUE_DEPTH - 2));
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + QPTR_W'(push.count);
      rd_ptr_in = rd_ptr_ff + QPTR_W'(do_pop);
      cnt_in    = cnt_ff + QCNT_W'(push.count) - QCNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_ptr_ff + QPTR_W'(1)] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

// File: sv/line_substring_matcher.sv
// Line filter: one text byte per item, fixed substring search per line.
// Throughput: one item per cycle while results drain; the matcher state
// (shift-and vector, counters) updates in the cycle an item is accepted.
// Results are registered into the queue as their item is accepted and offered
// in order; a four-entry result queue absorbs the two results of a final byte.
// Synchronous active-high reset clears registers, line state and the queue.
module line_substring_matcher
   import lsm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [7:0]            req_text_byte,
   input  logic                  req_end_of_text,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_result_kind,
   output logic [COUNT_W-1:0]    rsp_line_number,
   output logic [COUNT_W-1:0]    rsp_selected_count,
   output logic                  rsp_last_result,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   lsm_cfg_type    cfg_ff;
   lsm_reg_type    reg_sel;
   lsm_push_type   push;
   lsm_result_type head;
   logic           accept;
   logic           csr_write;

   assign pready    = 1'b1;
   assign reg_sel   = lsm_reg_type'(paddr[5:3]);
   assign csr_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_write) begin
         unique case (reg_sel)
            REG_PATTERN_LOW:    cfg_ff.pattern[63:0]   <= pwdata;
            REG_PATTERN_HIGH:   cfg_ff.pattern[127:64] <= pwdata;
            REG_PATTERN_LENGTH: cfg_ff.pattern_length  <= pwdata[CFG_LEN_W-1:0];
            REG_FOLD_CASE:      cfg_ff.fold_case       <= pwdata[0];
            REG_INVERT_SELECT:  cfg_ff.invert_select   <= pwdata[0];
            REG_TOTALS_ONLY:    cfg_ff.totals_only     <= pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_PATTERN_LOW:    prdata = cfg_ff.pattern[63:0];
         REG_PATTERN_HIGH:   prdata = cfg_ff.pattern[127:64];
         REG_PATTERN_LENGTH: prdata = CSR_DATA_W'(cfg_ff.pattern_length);
         REG_FOLD_CASE:      prdata = CSR_DATA_W'(cfg_ff.fold_case);
         REG_INVERT_SELECT:  prdata = CSR_DATA_W'(cfg_ff.invert_select);
         REG_TOTALS_ONLY:    prdata = CSR_DATA_W'(cfg_ff.totals_only);
         default:            prdata = '0;
      endcase
   end

   assign accept = req_valid && req_ready;

   lsm_match_core u_core (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .accept      (accept),
      .text_byte   (req_text_byte),
      .end_of_text (req_end_of_text),
      .push        (push)
   );

   lsm_result_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .pop        (rsp_ready),
      .head       (head),
      .head_valid (rsp_valid),
      .has_room   (req_ready)
   );

   assign rsp_result_kind    = head.result_kind;
   assign rsp_line_number    = head.line_number;
   assign rsp_selected_count = head.selected_count;
   assign rsp_last_result    = head.last_result;

endmodule

// File: sv/lsm_checker.sv
// Port-level checks of the line filter, bound to the top level below.
// Depends on lsm_pkg and line_substring_matcher_assert.svh.
`include "line_substring_matcher_assert.svh"

module lsm_checker
   import lsm_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               req_end_of_text,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic               rsp_result_kind,
   input logic [COUNT_W-1:0] rsp_line_number,
   input logic [COUNT_W-1:0] rsp_selected_count,
   input logic               rsp_last_result
);

   // queue is empty right after reset
   `LSM_ASSERT_NEXT_ANY(a_reset_empty, clock, reset, !rsp_valid)

   // a stalled result holds
   `LSM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_line_number) && $stable(rsp_selected_count))

   // a final byte accepted while the queue is empty yields a result the next cycle
   `LSM_ASSERT_NEXT(a_final_shows, clock, reset, req_valid && req_ready && req_end_of_text && !rsp_valid, rsp_valid)

   // final reports are flagged last, and selected lines never outnumber lines
   `LSM_ASSERT_NOW(a_report_sane, clock, reset, rsp_valid, (rsp_result_kind == rsp_last_result) && (rsp_selected_count <= rsp_line_number))

endmodule

bind line_substring_matcher lsm_checker u_lsm_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_ready          (req_ready),
   .req_end_of_text    (req_end_of_text),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_result_kind    (rsp_result_kind),
   .rsp_line_number    (rsp_line_number),
   .rsp_selected_count (rsp_selected_count),
   .rsp_last_result    (rsp_last_result)
);

// File: dv/line_substring_matcher_tb.sv
// Self-checking testbench of line_substring_matcher: a byte stream with random idling
// on both channels, register settings written over the APB-style port.
// Depends on lsm_pkg and line_substring_matcher from the RTL.
module line_substring_matcher_tb;
   import lsm_pkg::*;

   localparam int REG_UNMAPPED = 7;      // no register at this index
   localparam int RANDOM_ITEMS = 400;
   localparam int SETTLE       = 8;      // cycles allowed for in-flight work
   localparam int CYCLE_LIMIT  = 300000;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [7:0]            req_text_byte;
   logic                  req_end_of_text;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic                  rsp_result_kind;
   logic [COUNT_W-1:0]    rsp_line_number;
   logic [COUNT_W-1:0]    rsp_selected_count;
   logic                  rsp_last_result;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   // register shadow
   logic [63:0]          sh_pat_lo;
   logic [63:0]          sh_pat_hi;
   logic [CFG_LEN_W-1:0] sh_len;
   logic                 sh_ic;
   logic                 sh_inv;
   logic                 sh_totals_only;

   // line matcher state
   logic [15:0]        progress;
   logic               ln_found;
   logic               ln_open;
   logic [COUNT_W-1:0] line_cnt;
   logic [COUNT_W-1:0] sel_total;

   lsm_result_type expected_results[$];

   int  fail_count    = 0;
   int  items_sent    = 0;
   int  texts_closed  = 0;
   int  results_seen  = 0;
   int  settings_used = 0;
   int  cycles        = 0;
   int  ack_hold      = 0;
   bit  req_idle_on   = 1'b1;
   bit  rsp_idle_on   = 1'b1;

   line_substring_matcher dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_text_byte      (req_text_byte),
      .req_end_of_text    (req_end_of_text),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_result_kind    (rsp_result_kind),
      .rsp_line_number    (rsp_line_number),
      .rsp_selected_count (rsp_selected_count),
      .rsp_last_result    (rsp_last_result),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // ---------------------------------------------------------------- predictor

   function automatic logic [COUNT_W-1:0] count_up(input logic [COUNT_W-1:0] v);
      return (v == {COUNT_W{1'b1}}) ? v : v + 1'b1;
   endfunction

   function automatic logic [7:0] to_lower(input logic [7:0] b);
      return (sh_ic && b >= "A" && b <= "Z") ? b + 8'd32 : b;
   endfunction

   function automatic int active_len();
      return (sh_len > PATTERN_MAX) ? PATTERN_MAX : int'(sh_len);
   endfunction

   function automatic logic [7:0] pat_byte(input int i);
      return (i < 8) ? sh_pat_lo[8*i +: 8] : sh_pat_hi[8*(i-8) +: 8];
   endfunction

   task automatic clear_line();
      progress = '0;
      ln_found = 1'b0;
      ln_open  = 1'b0;
   endtask

   task automatic absorb_byte(input logic [7:0] c);
      int          len;
      logic [15:0] hits;
      len  = active_len();
      hits = '0;
      ln_open = 1'b1;
      if (len == 0) return;
      for (int i = 0; i < len; i++)
         if (to_lower(pat_byte(i)) == to_lower(c)) hits[i] = 1'b1;
      progress = ((progress << 1) | 16'd1) & hits;
      if (progress[len-1]) ln_found = 1'b1;
   endtask

   // closes the open line; report is set when a line report is due
   task automatic close_line(output bit report);
      bit hit;
      report = 1'b0;
      if (!ln_open) begin
         clear_line();
         return;
      end
      line_cnt = count_up(line_cnt);
      hit = (active_len() == 0) ? 1'b1 : ln_found;
      clear_line();
      if (sh_inv ? !hit : hit) begin
         sel_total = count_up(sel_total);
         report = !sh_totals_only;
      end
   endtask

   task automatic push_result(input logic kind, input logic last);
      lsm_result_type r;
      r.result_kind    = kind;
      r.line_number    = line_cnt;
      r.selected_count = sel_total;
      r.last_result    = last;
      expected_results.push_back(r);
   endtask

   task automatic model_byte(input logic [7:0] c, input logic eot);
      bit report;
      report = 1'b0;
      if (c == NEWLINE_BYTE) begin
         close_line(report);
      end else begin
         absorb_byte(c);
         if (eot) close_line(report);
      end
      if (report) push_result(KIND_LINE, 1'b0);
      if (eot) begin
         push_result(KIND_FINAL, 1'b1);
         clear_line();
         line_cnt  = '0;
         sel_total = '0;
         texts_closed++;
      end
   endtask

   // ---------------------------------------------------------------- drivers

   task automatic reg_write(input int idx, input logic [63:0] value);
      @(negedge clock);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b1;
      paddr   = CSR_ADDR_W'(idx * 8);
      pwdata  = value;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      case (idx)
         REG_PATTERN_LOW:    sh_pat_lo      = value;
         REG_PATTERN_HIGH:   sh_pat_hi      = value;
         REG_PATTERN_LENGTH: sh_len         = value[CFG_LEN_W-1:0];
         REG_FOLD_CASE:      sh_ic          = value[0];
         REG_INVERT_SELECT:  sh_inv         = value[0];
         REG_TOTALS_ONLY:    sh_totals_only = value[0];
         default: ;
      endcase
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
   endtask

   task automatic push_byte(input logic [7:0] c, input logic eot);
      int gap;
      gap = req_idle_on ? $urandom_range(0, 10) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid       = 1'b1;
      req_text_byte   = c;
      req_end_of_text = eot;
      do @(posedge clock); while (!req_ready);
      model_byte(c, eot);
      items_sent++;
   endtask

   // lowers valid, waits out every pending result, then lets in-flight work settle
   task automatic wait_idle();
      @(negedge clock);
      req_valid = 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_all(input logic [63:0] lo, input logic [63:0] hi,
                            input logic [63:0] len, input logic [63:0] ic,
                            input logic [63:0] inv, input logic [63:0] co);
      reg_write(REG_PATTERN_LOW, lo);
      reg_write(REG_PATTERN_HIGH, hi);
      reg_write(REG_PATTERN_LENGTH, len);
      reg_write(REG_FOLD_CASE, ic);
      reg_write(REG_INVERT_SELECT, inv);
      reg_write(REG_TOTALS_ONLY, co);
      settings_used++;
   endtask

   // ---------------------------------------------------------------- checker

   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (ack_hold > 0) begin
            rsp_ready = 1'b0;
            ack_hold--;
         end else begin
            rsp_ready = 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      lsm_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (expected_results.size() == 0) begin
            $error("result with no expectation: kind %0d line %0d count %0d last %0d",
                   rsp_result_kind, rsp_line_number, rsp_selected_count, rsp_last_result);
            fail_count++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_result_kind !== want.result_kind) begin
               $error("result_kind: expected %0d, got %0d", want.result_kind, rsp_result_kind);
               fail_count++;
            end
            if (rsp_line_number !== want.line_number) begin
               $error("line_number: expected %0d, got %0d", want.line_number, rsp_line_number);
               fail_count++;
            end
            if (rsp_selected_count !== want.selected_count) begin
               $error("selected_count: expected %0d, got %0d",
                      want.selected_count, rsp_selected_count);
               fail_count++;
            end
            if (rsp_last_result !== want.last_result) begin
               $error("last_result: expected %0d, got %0d", want.last_result, rsp_last_result);
               fail_count++;
            end
         end
         ack_hold = rsp_idle_on ? $urandom_range(0, 10) : 0;
      end
   end

   // ---------------------------------------------------------------- tests

   // default settings: empty pattern, every non-empty line selected,
   // empty line skipped, last byte not a newline
   task automatic test_empty_pattern();
      push_byte("a", 1'b0);
      push_byte(NEWLINE_BYTE, 1'b0);
      push_byte(NEWLINE_BYTE, 1'b0);
      push_byte("B", 1'b1);
      wait_idle();
   endtask

   // folded match with zero and 0xff bytes, text ending in a newline
   task automatic test_fold_and_zero_bytes();
      write_all(64'h0000_0000_00FF_0041, '1, 64'd3, 64'd1, 64'd0, 64'd0);
      push_byte("a", 1'b0);
      push_byte(8'h00, 1'b0);
      push_byte(8'hFF, 1'b0);
      push_byte(NEWLINE_BYTE, 1'b1);
      wait_idle();
   endtask

   // length beyond the pattern size acts as a full 16-byte pattern
   task automatic test_long_pattern();
      write_all(64'h4847_4645_4443_4241, 64'h504F_4E4D_4C4B_4A49, '1, 64'd0, 64'd0, 64'd0);
      for (int i = 0; i < 16; i++) push_byte(8'h41 + 8'(i), 1'b0);
      push_byte(NEWLINE_BYTE, 1'b1);
      wait_idle();
   endtask

   // inverted selection with line reports suppressed; a write to an
   // unmapped index must change nothing
   task automatic test_invert_totals_only();
      reg_write(REG_UNMAPPED, '1);
      reg_write(REG_INVERT_SELECT, 64'd1);
      reg_write(REG_TOTALS_ONLY, 64'd1);
      push_byte("x", 1'b0);
      push_byte(NEWLINE_BYTE, 1'b0);
      push_byte("q", 1'b1);
      wait_idle();
   endtask

   function automatic logic [7:0] pick_byte();
      logic [7:0] b;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: b = pat_byte($urandom_range(0, 15));
         4:          b = 8'h41 + 8'($urandom_range(0, 25));
         5:          b = $urandom_range(0, 1) ? 8'h00 : 8'hFF;
         6:          b = 8'($urandom_range(0, 255));
         default:    b = 8'h61 + 8'($urandom_range(0, 3));
      endcase
      return b;
   endfunction

   function automatic logic [7:0] pick_pattern_byte();
      case ($urandom_range(0, 7))
         0: return "a";
         1: return "b";
         2: return "A";
         3: return "B";
         4: return 8'h00;
         5: return 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // lines of random bytes, half of them carrying the pattern (case
   // swapped at random); closed texts end on a newline or on a line byte
   task automatic send_text(input bit closed);
      logic [7:0] txt[$];
      logic [7:0] b;
      int         len;
      int         nlines;
      len    = active_len();
      nlines = $urandom_range(1, 3);
      for (int l = 0; l < nlines; l++) begin
         repeat ($urandom_range(0, 6)) txt.push_back(pick_byte());
         if (len > 0 && $urandom_range(0, 1)) begin
            for (int i = 0; i < len; i++) begin
               b = pat_byte(i);
               if ($urandom_range(0, 3) == 0 && (b inside {["A":"Z"], ["a":"z"]}))
                  b = b ^ 8'h20;
               txt.push_back(b);
            end
         end
         repeat ($urandom_range(0, 4)) txt.push_back(pick_byte());
         if (l < nlines - 1 || !closed || $urandom_range(0, 1))
            txt.push_back(NEWLINE_BYTE);
      end
      if (txt.size() == 0) txt.push_back(NEWLINE_BYTE);
      foreach (txt[i]) push_byte(txt[i], closed && i == txt.size() - 1);
   endtask

   task automatic random_settings();
      logic [63:0] lo;
      logic [63:0] hi;
      logic [63:0] len;
      for (int i = 0; i < 8; i++) begin
         lo[8*i +: 8] = pick_pattern_byte();
         hi[8*i +: 8] = pick_pattern_byte();
      end
      len = {$urandom, $urandom};
      case ($urandom_range(0, 9))
         0:       len[4:0] = 5'd0;
         1:       len[4:0] = 5'd16;
         2:       len[4:0] = 5'($urandom_range(17, 31));
         default: len[4:0] = 5'($urandom_range(1, 4));
      endcase
      write_all(lo, hi, len, {$urandom, $urandom}, {$urandom, $urandom},
                {$urandom, $urandom});
   endtask

   // several register settings in turn, extremes first and last; a phase
   // may end mid-text so that the next setting applies to an open text
   task automatic test_random_phases();
      int target;
      target = items_sent + RANDOM_ITEMS;
      write_all('1, '1, '1, '1, '1, '1);
      while (items_sent < target) begin
         req_idle_on = ($urandom_range(0, 3) != 0);
         rsp_idle_on = ($urandom_range(0, 3) != 0);
         repeat ($urandom_range(2, 4)) send_text(1'b1);
         send_text($urandom_range(0, 2) != 0);
         wait_idle();
         random_settings();
      end
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      write_all('0, '0, '0, '0, '0, '0);
      send_text(1'b1);
      wait_idle();
   endtask

   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_text_byte   = '0;
      req_end_of_text = 1'b0;
      psel            = 1'b0;
      penable         = 1'b0;
      pwrite          = 1'b0;
      paddr           = '0;
      pwdata          = '0;
      sh_pat_lo       = '0;
      sh_pat_hi       = '0;
      sh_len          = '0;
      sh_ic           = 1'b0;
      sh_inv          = 1'b0;
      sh_totals_only  = 1'b0;
      line_cnt        = '0;
      sel_total       = '0;
      clear_line();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_empty_pattern();
      test_fold_and_zero_bytes();
      test_long_pattern();
      test_invert_totals_only();
      test_random_phases();

      if (expected_results.size() != 0) begin
         $error("%0d expected results never arrived", expected_results.size());
         fail_count++;
      end
      $display("sent %0d text bytes forming %0d complete texts under %0d register settings",
               items_sent, texts_closed, settings_used);
      $display("checked %0d results, %0d mismatches", results_seen, fail_count);
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
